FILE: rtl/core/symbol_address_floor_lookup_top_defines.svh
// Assertion macros for the symbol address floor lookup block.
// Included by the top level; depends on nothing else.
`ifndef SYMBOL_ADDRESS_FLOOR_LOOKUP_TOP_DEFINES_SVH
`define SYMBOL_ADDRESS_FLOOR_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAFL_ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("safl assertion failed");

// Next-cycle implication, disabled during reset.
`define SAFL_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("safl assertion failed");

`endif

FILE: rtl/core/safl_pkg.sv
// Shared types and constants for the symbol address floor lookup block.
// Used by the table cells, the scan unit and the top level.
package safl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int ADDR_W = 32;
  localparam int NAME_W = 32;
  localparam int COUNT_OUT_W = 7;

  localparam logic [3:0] TYPE_FUNCTION = 4'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } st_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [NAME_W-1:0] name;
    logic [ADDR_W-1:0] distance;
  } scan_res_t;

endpackage

FILE: rtl/core/safl_cell.sv
// One table cell: holds a symbol start address and name offset.
// Depends on safl_pkg; neighbors are wired up by the top level.
module safl_cell import safl_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic [ADDR_W-1:0] new_addr,
  input  logic [NAME_W-1:0] new_name,
  input  logic              gt_prev,
  input  logic [ADDR_W-1:0] left_addr,
  input  logic [NAME_W-1:0] left_name,
  input  logic [ADDR_W-1:0] right_addr,
  input  logic [NAME_W-1:0] right_name,
  output logic              gt,
  output logic [ADDR_W-1:0] addr,
  output logic [NAME_W-1:0] name
);

  logic held;
  logic at_end;
  logic load_new;
  logic take_left;

  assign held   = CNT_W'(INDEX) < count;
  assign at_end = CNT_W'(INDEX) == count;
  // A held entry above the new address moves one cell up.
  assign gt        = held && (addr > new_addr);
  assign take_left = ctl.insert && gt_prev;
  assign load_new  = ctl.insert && !gt_prev && (gt || at_end);

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      addr <= right_addr;
      name <= right_name;
    end else if (take_left) begin
      addr <= left_addr;
      name <= left_name;
    end else if (load_new) begin
      addr <= new_addr;
      name <= new_name;
    end
  end

endmodule

FILE: rtl/core/safl_scan.sv
// Lookup scan unit: watches the head cell while the table rotates once.
// Depends on safl_pkg; keeps the best candidate seen so far.
module safl_scan import safl_pkg::*; #(
  parameter int DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] lookup_addr,
  input  logic [CNT_W-1:0]  count,
  input  logic [ADDR_W-1:0] entry_addr,
  input  logic [NAME_W-1:0] entry_name,
  output logic              rotate,
  output scan_res_t         res
);

  localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

  logic              active;
  logic              done;
  logic              hit;
  logic [STEP_W-1:0] step;
  logic [ADDR_W-1:0] lk_addr;
  logic [ADDR_W-1:0] best_addr;
  logic [NAME_W-1:0] best_name;
  logic              better;

  // Strictly greater keeps the earliest of equal starts.
  assign better = (CNT_W'(step) < count) && (entry_addr <= lk_addr) &&
                  (!hit || (entry_addr > best_addr));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      hit    <= 1'b0;
      step   <= '0;
    end else begin
      done <= !start && active && (step == LAST_STEP);
      if (start) begin
        active <= 1'b1;
        hit    <= 1'b0;
        step   <= '0;
      end else if (active) begin
        if (better) begin
          hit <= 1'b1;
        end
        if (step == LAST_STEP) begin
          active <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lk_addr <= lookup_addr;
    end
    if (active && better) begin
      best_addr <= entry_addr;
      best_name <= entry_name;
    end
  end

  assign rotate       = active;
  assign res.done     = done;
  assign res.found    = hit;
  assign res.name     = hit ? best_name : '0;
  assign res.distance = hit ? (lk_addr - best_addr) : '0;

endmodule

FILE: rtl/core/symbol_address_floor_lookup_top.sv
// Top level of the symbol address floor lookup block.
// Depends on safl_pkg, safl_cell, safl_scan and the assertion macro header.
//
// Usage:
//   Requests arrive on in_valid/in_ready with command, address, name_offset
//   and symbol_type; each request gives exactly one result on
//   out_valid/out_ready (found, found_name, distance, entry_count, dropped).
//   The table is a row of TABLE_DEPTH cells kept sorted by start address.
//   Clear and insert need no scan: an insert shifts the cells above
//   the new address up by one in parallel, and the result is registered at
//   the accept edge, so it shows in the next cycle.
//   A lookup rotates the whole row once toward cell zero while the scan unit
//   compares the head entry; the scan unit registers its done flag at the end
//   of the rotation, and the result is then registered in the output register.
//   One request is in work at a time; a new request is taken while a result
//   is being handed over in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   in_ready stays low until it is taken.
//   Reset empties the table (count to zero) and drops any pending result;
//   cell contents are left as they are.
`include "symbol_address_floor_lookup_top_defines.svh"

module symbol_address_floor_lookup_top import safl_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [ADDR_W-1:0]      address,
  input  logic [NAME_W-1:0]      name_offset,
  input  logic [3:0]             symbol_type,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [NAME_W-1:0]      found_name,
  output logic [ADDR_W-1:0]      distance,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   dropped
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  st_t              state;
  st_t              state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
  logic             accept;
  logic             insert_ok;
  logic             full;
  logic             lookup_start;
  cell_ctl_t        ctl;
  scan_res_t        scan_res;
  logic             rotate;

  logic [ADDR_W-1:0] cell_addr [TABLE_DEPTH];
  logic [NAME_W-1:0] cell_name [TABLE_DEPTH];
  logic              cell_gt   [TABLE_DEPTH];

  assign accept       = in_valid && in_ready;
  assign insert_ok    = (command == CMD_INSERT) && (symbol_type == TYPE_FUNCTION) &&
                        (address != '0);
  assign full         = count == FULL_COUNT;
  assign lookup_start = accept && (command == CMD_LOOKUP);
  assign ctl.insert   = accept && insert_ok && !full;
  assign ctl.rotate   = rotate;

  // Table row: cell zero holds the lowest start address.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    safl_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .new_addr   (address),
      .new_name   (name_offset),
      .gt_prev    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .left_addr  (cell_addr[(i == 0) ? 0 : i - 1]),
      .left_name  (cell_name[(i == 0) ? 0 : i - 1]),
      .right_addr (cell_addr[(i + 1) % TABLE_DEPTH]),
      .right_name (cell_name[(i + 1) % TABLE_DEPTH]),
      .gt         (cell_gt[i]),
      .addr       (cell_addr[i]),
      .name       (cell_name[i])
    );
  end

  safl_scan #(
    .DEPTH (TABLE_DEPTH),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (lookup_start),
    .lookup_addr (address),
    .count       (count),
    .entry_addr  (cell_addr[0]),
    .entry_name  (cell_name[0]),
    .rotate      (rotate),
    .res         (scan_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (lookup_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    unique case (state)
      ST_IDLE: in_ready = !out_valid || out_ready;
      ST_SCAN: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (command)
        CMD_CLEAR:  count_next = '0;
        CMD_INSERT: begin
          if (insert_ok && !full) begin
            count_next = count + 1'b1;
          end
        end
        default: count_next = count;
      endcase
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((accept && (command != CMD_LOOKUP)) || scan_res.done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; a lookup leaves the count unchanged.
  always_ff @(posedge clk) begin
    if (scan_res.done) begin
      found       <= scan_res.found;
      found_name  <= scan_res.name;
      distance    <= scan_res.distance;
      entry_count <= count_ext[COUNT_OUT_W-1:0];
      dropped     <= 1'b0;
    end else if (accept && (command != CMD_LOOKUP)) begin
      found       <= 1'b0;
      found_name  <= '0;
      distance    <= '0;
      entry_count <= count_ext[COUNT_OUT_W-1:0];
      dropped     <= insert_ok && full;
    end
  end

  `SAFL_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FULL_COUNT)
  `SAFL_ASSERT_NEXT(a_lookup_scans, clk, rst, lookup_start, state == ST_SCAN)
  `SAFL_ASSERT_IMPL(a_done_in_scan, clk, rst, scan_res.done, state == ST_SCAN)
  `SAFL_ASSERT_IMPL(a_drop_when_full, clk, rst, out_valid && dropped, count == FULL_COUNT)

endmodule
